// File: rtl/sida_pkg.sv
// Shared constants and control types of the signed integer to decimal ASCII converter.
package sida_pkg;

  // Default configuration of the converter.
  localparam int unsigned InputBitsDefault = 32;
  localparam int unsigned MaxDigitsDefault = 10;

  // Width of one BCD digit and the double-dabble correction values.
  localparam int unsigned DigitBits = 4;
  localparam logic [DigitBits-1:0] AdjLimit = 4'd5;
  localparam logic [DigitBits-1:0] AdjAdd = 4'd3;

  // ASCII codes that the converter emits.
  localparam logic [6:0] CharZero = 7'd48;
  localparam logic [6:0] CharMinus = 7'd45;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new number and clear the BCD register
    logic shift;     // one double-dabble step
    logic emit;      // write a character into the output register
    logic sel_sign;  // the emitted character is the minus sign
    logic last;      // the emitted character closes the number
  } sida_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the output register can take a character this cycle
    logic neg;       // the captured number is negative
  } sida_status_t;

endpackage

// File: rtl/sida_datapath.sv
// Datapath: magnitude shifter, double-dabble BCD register and the output register.
module sida_datapath
  import sida_pkg::*;
#(
  parameter int unsigned INPUT_BITS = InputBitsDefault,
  parameter int unsigned MAX_DIGITS = MaxDigitsDefault,
  localparam int unsigned IdxW = $clog2(MAX_DIGITS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [INPUT_BITS-1:0] number_i,
  input  sida_cmd_t                    cmd_i,
  input  logic        [IdxW-1:0]       digit_idx_i,
  input  logic                         out_stall_i,
  output sida_status_t                 status_o,
  output logic        [IdxW-1:0]       top_idx_o,
  output logic                         out_valid_o,
  output logic        [6:0]            character_o,
  output logic                         last_o
);

  localparam int unsigned BcdW = MAX_DIGITS * DigitBits;

  logic [INPUT_BITS-1:0] mag_q, mag_d, abs_val;
  logic [BcdW-1:0]       bcd_q, bcd_d, bcd_adj;
  logic                  neg_q, neg_d;
  logic                  ovf_q, ovf_d;
  logic                  out_valid_q, out_valid_d;
  logic [6:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic [DigitBits-1:0]  sel_digit;
  logic [IdxW-1:0]       top_idx;

  // Magnitude of the input, taken as an unsigned value so the most negative number is exact.
  assign abs_val = number_i[INPUT_BITS-1] ? (~number_i + 1'b1) : number_i;

  // Add-3 correction on every digit that is five or more before the shift.
  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (bcd_q[k*DigitBits +: DigitBits] >= AdjLimit) begin
        bcd_adj[k*DigitBits +: DigitBits] = bcd_q[k*DigitBits +: DigitBits] + AdjAdd;
      end else begin
        bcd_adj[k*DigitBits +: DigitBits] = bcd_q[k*DigitBits +: DigitBits];
      end
    end
  end

  // Conversion registers: load, or shift one bit of the magnitude into the BCD digits.
  // A bit that leaves the top digit means the value has more digits than are kept.
  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    ovf_d = ovf_q;
    if (cmd_i.load) begin
      mag_d = abs_val;
      bcd_d = '0;
      neg_d = number_i[INPUT_BITS-1];
      ovf_d = 1'b0;
    end else if (cmd_i.shift) begin
      mag_d = {mag_q[INPUT_BITS-2:0], 1'b0};
      bcd_d = {bcd_adj[BcdW-2:0], mag_q[INPUT_BITS-1]};
      ovf_d = ovf_q | bcd_adj[BcdW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= '0;
      neg_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

  // Index of the most significant digit to print; all kept digits when the value overflowed.
  always_comb begin
    top_idx = '0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (bcd_q[k*DigitBits +: DigitBits] != '0) begin
        top_idx = IdxW'(k);
      end
    end
    if (ovf_q) begin
      top_idx = IdxW'(MAX_DIGITS - 1);
    end
  end

  assign top_idx_o = top_idx;

  // Output register: a new character enters when the slot is empty or is being taken.
  assign sel_digit = bcd_q[digit_idx_i*DigitBits +: DigitBits];

  always_comb begin
    out_valid_d = out_valid_q;
    char_d = char_q;
    last_d = last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      char_d = cmd_i.sel_sign ? CharMinus : (CharZero + {3'b000, sel_digit});
      last_d = cmd_i.last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.neg = neg_q;
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o = last_q;

endmodule

// File: rtl/sida_ctrl.sv
// Controller: sequences conversion steps and character emission for one number.
module sida_ctrl
  import sida_pkg::*;
#(
  parameter int unsigned INPUT_BITS = InputBitsDefault,
  parameter int unsigned MAX_DIGITS = MaxDigitsDefault,
  localparam int unsigned IdxW = $clog2(MAX_DIGITS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sida_status_t      status_i,
  input  logic [IdxW-1:0]   top_idx_i,
  output sida_cmd_t         cmd_o,
  output logic [IdxW-1:0]   digit_idx_o
);

  localparam int unsigned CntW = $clog2(INPUT_BITS + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StDigits = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;

  assign in_stall_o = (state_q != StIdle);

  // Next state, step counter and digit index.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d = CntW'(INPUT_BITS);
          state_d = StConv;
        end
      end
      StConv: begin
        if (cnt_q != '0) begin
          cmd_o.shift = 1'b1;
          cnt_d = cnt_q - 1'b1;
        end else begin
          idx_d = top_idx_i;
          state_d = status_i.neg ? StSign : StDigits;
        end
      end
      StSign: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel_sign = 1'b1;
          state_d = StDigits;
        end
      end
      StDigits: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  assign digit_idx_o = idx_q;

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Each accepted number is printed as ASCII, most significant character first: a leading '-'
// for negative values, then the decimal digits of the magnitude with no leading zeros, and
// last_o marks the final character (zero prints as a single '0'). Each number passes through
// the accept, one double-dabble shift per magnitude bit in the datapath's BCD register and a
// step that locates the leading digit; its characters then enter the output register one per
// cycle, except while a character cannot enter because the output register is full and
// stalled. A new number is accepted once the previous one's final character has entered the
// output register, even while that character still waits to be taken.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int unsigned INPUT_BITS = InputBitsDefault,
  parameter int unsigned MAX_DIGITS = MaxDigitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [INPUT_BITS-1:0] number_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic        [6:0]            character_o,
  output logic                         last_o
);

  localparam int unsigned IdxW = $clog2(MAX_DIGITS);

  sida_cmd_t       cmd;
  sida_status_t    status;
  logic [IdxW-1:0] digit_idx;
  logic [IdxW-1:0] top_idx;

  // Sequencer for conversion and emission.
  sida_ctrl #(
    .INPUT_BITS(INPUT_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .top_idx_i  (top_idx),
    .cmd_o      (cmd),
    .digit_idx_o(digit_idx)
  );

  // Conversion registers and output register.
  sida_datapath #(
    .INPUT_BITS(INPUT_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .number_i   (number_i),
    .cmd_i      (cmd),
    .digit_idx_i(digit_idx),
    .out_stall_i(out_stall_i),
    .status_o   (status),
    .top_idx_o  (top_idx),
    .out_valid_o(out_valid_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 100ps

module testbench;
  import sida_pkg::*;

  localparam int unsigned NumBits = InputBitsDefault;
  localparam int unsigned DigitSlots = MaxDigitsDefault;
  localparam int unsigned ChunkItems = 100;
  localparam int unsigned Chunks = 4;
  localparam int unsigned CalmItems = 50;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ReportLimit = 10;

  // Directed values: zero, single digits, decade edges, interior zeros and both extremes.
  localparam int DirectedNumbers [23] = '{
    0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 101, 12345, -600,
    999999999, -999999999, 1000000000, -1000000000, 1000000007,
    1999999999, 2000000000, 2147483647, -2147483647, 32'sh8000_0000
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [NumBits-1:0] number_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [6:0]                character_o;
  logic                      last_o;

  // Numbers waiting to be sent and the characters they should produce, oldest first.
  logic [NumBits-1:0] pending_numbers [$];
  logic [6:0]         expected_chars [$];
  logic               expected_lasts [$];

  logic        in_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          stimulus_loaded = 1'b0;

  int unsigned mismatches = 0;
  int unsigned numbers_sent = 0;
  int unsigned negatives_sent = 0;
  int unsigned zeros_sent = 0;
  int unsigned chars_checked = 0;

  signed_int_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Appends the characters that one number prints: optional sign, then digits MSD first.
  task automatic queue_decimal_text(input logic [NumBits-1:0] value);
    logic [NumBits-1:0] magnitude;
    logic [3:0]         digits [DigitSlots];
    int                 count;
    magnitude = value[NumBits-1] ? (~value + 1'b1) : value;
    count = 0;
    do begin
      digits[count] = 4'(magnitude % 10);
      magnitude = magnitude / 10;
      count++;
    end while (magnitude != 0 && count < DigitSlots);
    if (value[NumBits-1]) begin
      expected_chars.push_back(CharMinus);
      expected_lasts.push_back(1'b0);
    end
    for (int i = count - 1; i >= 0; i--) begin
      expected_chars.push_back(CharZero + 7'(digits[i]));
      expected_lasts.push_back(i == 0);
    end
  endtask

  // Random number biased toward every digit count, decade edges and the extremes.
  function automatic logic [NumBits-1:0] random_number();
    longint unsigned span;
    longint unsigned wide;
    int unsigned     pick;
    logic [NumBits-1:0] value;
    pick = $urandom_range(99);
    span = 1;
    if (pick < 35) begin
      value = $urandom;
    end else if (pick < 65) begin
      repeat ($urandom_range(1, DigitSlots)) span = span * 10;
      wide = {$urandom, $urandom};
      value = NumBits'(wide % span);
      if ($urandom_range(1)) value = -value;
    end else if (pick < 80) begin
      repeat ($urandom_range(0, DigitSlots - 1)) span = span * 10;
      value = NumBits'(span + $urandom_range(2) - 1);
      if ($urandom_range(1)) value = -value;
    end else if (pick < 90) begin
      value = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                : 32'h7fff_ffff - $urandom_range(3);
    end else begin
      value = NumBits'($urandom_range(40)) - 20;
    end
    return value;
  endfunction

  // Near the end of the run neither side idles.
  function automatic bit tail_phase();
    return stimulus_loaded && pending_numbers.size() < CalmItems;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < ReportLimit) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // Holds until nothing is queued, nothing is offered and every character has been checked.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_numbers.size() != 0 || in_valid_i || expected_chars.size() != 0);
  endtask

  // Driver: offers numbers from the queue and stalls the output side, both in random bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      if (!in_valid_i || in_taken) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_numbers.size() != 0) begin
          in_valid_i <= 1'b1;
          number_i <= pending_numbers.pop_front();
          if (!tail_phase() && $urandom_range(5) == 0) send_gap <= $urandom_range(1, 17);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!tail_phase() && $urandom_range(4) == 0) begin
        out_stall_i <= 1'b1;
        stall_left <= $urandom_range(16);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each input transfer, checks each output transfer, runs the watchdog.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          note_mismatch($sformatf("unexpected character %0d last %0b", character_o, last_o));
        end else begin
          if (character_o !== expected_chars[0])
            note_mismatch($sformatf("character expected %0d got %0d",
                                    expected_chars[0], character_o));
          if (last_o !== expected_lasts[0])
            note_mismatch($sformatf("last expected %0b got %0b (character %0d)",
                                    expected_lasts[0], last_o, expected_chars[0]));
          void'(expected_chars.pop_front());
          void'(expected_lasts.pop_front());
        end
      end
      if (in_valid_i && !in_stall_o) begin
        queue_decimal_text(number_i);
        numbers_sent++;
        if (number_i < 0) negatives_sent++;
        if (number_i == 0) zeros_sent++;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
        $display("Watchdog: no transfer for %0d cycles", WatchdogLimit);
        $display("testbench failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus sequence: reset, directed values, then random chunks with a full drain after each.
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    foreach (DirectedNumbers[i]) pending_numbers.push_back(DirectedNumbers[i]);
    wait_drained();

    for (int c = 0; c < Chunks; c++) begin
      repeat (ChunkItems) pending_numbers.push_back(random_number());
      if (c == Chunks - 1) stimulus_loaded = 1'b1;
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (expected_chars.size() != 0)
      note_mismatch($sformatf("%0d expected characters never arrived", expected_chars.size()));

    $display("Converted %0d numbers (%0d negative, %0d zero) into %0d checked characters.",
             numbers_sent, negatives_sent, zeros_sent, chars_checked);
    $display("Mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sida_pkg.sv
rtl/sida_datapath.sv
rtl/sida_ctrl.sv
rtl/signed_int_to_decimal_ascii.sv
dv/testbench.sv
